// ===== rtl/sacov_pkg.sv =====
// ----------------------------------------------------------------------------
// sacov_pkg
// shared widths, request and status codes, and the queued word type
// ----------------------------------------------------------------------------
package sacov_pkg;

    localparam int MAX_LAG_DEF    = 16;
    localparam int COUNT_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int REQ_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int LAG_W    = 5;
    localparam int CFG_W    = 5;
    localparam int PROD_W   = 56;
    localparam int EARLY_W  = 22;
    localparam int SUM_W    = 41;
    localparam int ACOV_W   = 48;
    localparam int STAT_W   = 2;
    localparam int TOTAL_W  = 24;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LAG = 2'd2;

    localparam logic [CFG_W-1:0] LAGS_RESET = 5'd16;

    typedef struct packed {
        logic [REQ_W-1:0]           req;
        logic signed [SAMPLE_W-1:0] sample;
        logic [LAG_W-1:0]           lag;
    } item_t;

endpackage

// ===== rtl/sacov_front.sv =====
// ----------------------------------------------------------------------------
// sacov_front
// input handshake, drops unused request codes, two-entry word queue
// ----------------------------------------------------------------------------
module sacov_front
    import sacov_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [REQ_W-1:0]           req_type,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [LAG_W-1:0]           lag,
    output item_t                      item,
    output logic                       item_valid,
    input  logic                       item_pop
);

    localparam logic [1:0] DEPTH = 2'd2;

    item_t      q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready   = cnt_reg != DEPTH;
    assign item_valid = cnt_reg != 2'd0;
    assign item       = q_reg[rp_reg];
    // unused request codes are taken and dropped here
    assign push = in_valid && in_ready && (req_type != REQ_NONE);
    assign pop  = item_pop && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].req    <= req_type;
            q_reg[wp_reg].sample <= sample;
            q_reg[wp_reg].lag    <= lag;
        end
    end

endmodule

// ===== rtl/sacov_query.sv =====
// ----------------------------------------------------------------------------
// sacov_query
// estimate for one lag: shift-add multiplier, restoring divider, saturation
// ----------------------------------------------------------------------------
module sacov_query
    import sacov_pkg::*;
#(
    parameter int MAX_LAG    = MAX_LAG_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(MAX_LAG+1)-1:0]        lag_in,
    input  logic signed [PROD_W-1:0]            prod_in,
    input  logic signed [EARLY_W-1:0]           early_in,
    input  logic signed [SUM_W-1:0]             sum_in,
    input  logic [COUNT_BITS-1:0]               count_in,
    input  logic [MAX_LAG:0][SAMPLE_W-1:0]      hist,
    output logic                                busy,
    output logic                                done,
    output logic signed [ACOV_W-1:0]            result
);

    localparam int HIW = $clog2(MAX_LAG+1);
    localparam int NW  = 2*COUNT_BITS + FRAC_BITS + 64;
    localparam int AW  = SUM_W + 3;
    localparam int MBW = (COUNT_BITS + 2 > AW) ? COUNT_BITS + 2 : AW;
    localparam int CW  = $clog2(((NW > MAX_LAG) ? NW : MAX_LAG) + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LSUM = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_SAT  = 3'd6;

    localparam logic [2:0] PH_LAST = 3'd7;

    localparam logic [NW-1:0] MAXPOS = NW'({1'b0, {(ACOV_W-1){1'b1}}});
    localparam logic [ACOV_W-1:0] SAT_POS = {1'b0, {(ACOV_W-1){1'b1}}};
    localparam logic [ACOV_W-1:0] SAT_NEG = {1'b1, {(ACOV_W-1){1'b0}}};

    logic [2:0]                 state_reg;
    logic [2:0]                 ph_reg;
    logic [CW-1:0]              cnt_reg;
    logic [HIW-1:0]             lag_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [EARLY_W-1:0]  early_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [COUNT_BITS-1:0]      n_reg;
    logic signed [SUM_W-1:0]    lsum_reg;
    logic signed [NW-1:0]       num_reg, t_reg, den_reg, acc_reg, mcand_reg;
    logic [MBW-1:0]             mb_reg;
    logic                       msign_reg, neg_reg;
    logic [NW:0]                rem_reg;

    logic signed [NW-1:0]  ma, prod_r, mag;
    logic signed [MBW-1:0] mb, mb_n, mb_abs;
    logic signed [AW-1:0]  a_val;
    logic [NW:0]           rs;
    logic                  ge;
    logic [NW-1:0]         nq;

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_SAT;

    assign a_val = (AW'(sum_reg) <<< 1) - AW'(lsum_reg) - AW'(early_reg);
    assign mb_n  = MBW'($signed({1'b0, n_reg}));

    // operand pair for each product of the numerator and denominator
    always_comb
    begin
        case (ph_reg)
            3'd0:    begin ma = NW'(prod_reg); mb = mb_n; end
            3'd2:    begin ma = NW'(sum_reg);  mb = mb_n; end
            3'd3:    begin ma = t_reg;         mb = MBW'(a_val); end
            3'd4:    begin ma = NW'(sum_reg);  mb = MBW'(sum_reg); end
            3'd5:    begin ma = t_reg;
                           mb = mb_n - MBW'($signed({1'b0, lag_reg})); end
            3'd6:    begin ma = NW'($signed({1'b0, n_reg})); mb = mb_n; end
            default: begin ma = t_reg;         mb = mb_n; end
        endcase
    end

    assign mb_abs = mb[MBW-1] ? -mb : mb;
    assign prod_r = msign_reg ? -acc_reg : acc_reg;
    assign mag    = num_reg[NW-1] ? -num_reg : num_reg;
    assign rs     = {rem_reg[NW-1:0], num_reg[NW-1]};
    assign ge     = rs >= {1'b0, den_reg};
    assign nq     = -num_reg;

    always_comb
    begin
        if (!neg_reg)
            result = (num_reg > MAXPOS) ? SAT_POS : num_reg[ACOV_W-1:0];
        else
            result = (num_reg > MAXPOS + NW'(1)) ? SAT_NEG : nq[ACOV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= 3'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_LSUM;
                        cnt_reg   <= '0;
                        ph_reg    <= 3'd0;
                    end
                end
                S_LSUM:
                begin
                    if (cnt_reg == CW'(lag_reg))
                        state_reg <= S_LOAD;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (cnt_reg == CW'(MBW))
                    begin
                        ph_reg    <= ph_reg + 3'd1;
                        state_reg <= (ph_reg == PH_LAST) ? S_POST : S_LOAD;
                    end
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end
                S_POST:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == CW'(NW))
                        state_reg <= S_SAT;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end
                S_SAT:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lag_reg   <= lag_in;
                    prod_reg  <= prod_in;
                    early_reg <= early_in;
                    sum_reg   <= sum_in;
                    n_reg     <= count_in;
                    lsum_reg  <= '0;
                end
            end
            S_LSUM:
            begin
                if (cnt_reg != CW'(lag_reg))
                    lsum_reg <= lsum_reg + SUM_W'($signed(hist[cnt_reg[HIW-1:0]]));
            end
            S_LOAD:
            begin
                acc_reg   <= '0;
                mcand_reg <= ma;
                mb_reg    <= mb_abs;
                msign_reg <= mb[MBW-1];
            end
            S_MUL:
            begin
                if (cnt_reg == CW'(MBW))
                begin
                    case (ph_reg)
                        3'd1:    num_reg <= prod_r;
                        3'd3:    num_reg <= num_reg - prod_r;
                        3'd5:    num_reg <= num_reg + prod_r;
                        3'd7:    den_reg <= prod_r;
                        default: t_reg   <= prod_r;
                    endcase
                end
                else
                begin
                    if (mb_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg <= mcand_reg <<< 1;
                    mb_reg    <= mb_reg >> 1;
                end
            end
            S_POST:
            begin
                // rounding: (|num| * 2^(f+1) + den) / (2 den)
                neg_reg <= num_reg[NW-1];
                num_reg <= (mag <<< (FRAC_BITS + 1)) + den_reg;
                den_reg <= den_reg <<< 1;
                rem_reg <= '0;
            end
            S_DIV:
            begin
                if (cnt_reg != CW'(NW))
                begin
                    rem_reg <= ge ? rs - {1'b0, den_reg} : rs;
                    num_reg <= {num_reg[NW-2:0], ge};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/sacov_back.sv =====
// ----------------------------------------------------------------------------
// sacov_back
// lag cells, sums, count, config register and output register
// ----------------------------------------------------------------------------
module sacov_back
    import sacov_pkg::*;
#(
    parameter int MAX_LAG    = MAX_LAG_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  item_t                           item,
    input  logic                            item_valid,
    output logic                            item_pop,
    input  logic                            cfg_we,
    input  logic [CFG_W-1:0]                cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [ACOV_W-1:0]        autocov,
    output logic [STAT_W-1:0]               status,
    output logic [TOTAL_W-1:0]              sample_total,
    output logic                            q_start,
    input  logic                            q_busy,
    input  logic                            q_done,
    input  logic signed [ACOV_W-1:0]        q_result,
    output logic [$clog2(MAX_LAG+1)-1:0]    q_lag,
    output logic signed [PROD_W-1:0]        q_prod,
    output logic signed [EARLY_W-1:0]       q_early,
    output logic signed [SUM_W-1:0]         q_sum,
    output logic [COUNT_BITS-1:0]           q_count,
    output logic [MAX_LAG:0][SAMPLE_W-1:0]  hist
);

    localparam int HIW = $clog2(MAX_LAG+1);
    localparam int LW  = HIW + LAG_W;
    localparam int IW  = ((COUNT_BITS > HIW) ? COUNT_BITS : HIW) + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [MAX_LAG:0][SAMPLE_W-1:0] hist_reg;
    logic signed [PROD_W-1:0]       prod_reg  [MAX_LAG+1];
    logic signed [EARLY_W-1:0]      early_reg [MAX_LAG+1];
    logic signed [SUM_W-1:0]        sum_reg;
    logic [COUNT_BITS-1:0]          count_reg;
    logic [CFG_W-1:0]               lags_reg;
    logic                           out_valid_reg;

    logic          is_query, is_add, is_clear, go, bad, empty, slot_free, do_add;
    logic [LW-1:0] limit, k_w;
    logic [HIW-1:0] idx;

    assign is_query  = item.req == REQ_QUERY;
    assign is_add    = item.req == REQ_ADD;
    assign is_clear  = item.req == REQ_CLEAR;
    assign slot_free = !out_valid_reg || out_ready;
    assign go        = item_valid && !q_busy && (!is_query || slot_free);
    assign item_pop  = go;

    assign limit = (LW'(lags_reg) > LW'(MAX_LAG)) ? LW'(MAX_LAG) : LW'(lags_reg);
    assign k_w   = LW'(item.lag);
    assign bad   = k_w > limit;
    assign empty = count_reg == '0;
    assign idx   = bad ? '0 : HIW'(item.lag);
    assign do_add = go && is_add && (count_reg != CMAX);

    assign q_start = go && is_query && !bad && !empty;
    assign q_lag   = idx;
    assign q_prod  = prod_reg[idx];
    assign q_early = early_reg[idx];
    assign q_sum   = sum_reg;
    assign q_count = count_reg;
    assign hist    = hist_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            lags_reg  <= LAGS_RESET;
            for (int i = 0; i <= MAX_LAG; i++)
            begin
                prod_reg[i]  <= '0;
                early_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                lags_reg <= cfg_wdata;
            if (go && is_clear)
            begin
                hist_reg  <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
                for (int i = 0; i <= MAX_LAG; i++)
                begin
                    prod_reg[i]  <= '0;
                    early_reg[i] <= '0;
                end
            end
            else if (do_add)
            begin
                hist_reg[0] <= item.sample;
                for (int i = 1; i <= MAX_LAG; i++)
                    hist_reg[i] <= hist_reg[i-1];
                // lag zero is always reached
                prod_reg[0] <= prod_reg[0] + PROD_W'(32'(item.sample)
                               * 32'(item.sample));
                // every lag cell updates in parallel from the new sample
                for (int i = 1; i <= MAX_LAG; i++)
                begin
                    if (IW'(i) <= IW'(count_reg))
                        prod_reg[i] <= prod_reg[i] + PROD_W'(32'(item.sample)
                                       * 32'($signed(hist_reg[i-1])));
                    else
                        early_reg[i] <= early_reg[i] + EARLY_W'(item.sample);
                end
                sum_reg   <= sum_reg + SUM_W'(item.sample);
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_done || (go && is_query && (bad || empty)))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_done)
        begin
            autocov      <= q_result;
            status       <= ST_OK;
            sample_total <= TOTAL_W'(count_reg);
        end
        else if (go && is_query && (bad || empty))
        begin
            autocov      <= '0;
            status       <= bad ? ST_BAD_LAG : ST_EMPTY;
            sample_total <= TOTAL_W'(count_reg);
        end
    end

endmodule

// ===== rtl/streaming_autocovariance.sv =====
// ----------------------------------------------------------------------------
// streaming_autocovariance
// streaming sample autocovariance estimator with lag queries
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries req_type, sample and lag; add,
// clear and unused codes give no output word, a query gives one word of
// autocov, status and sample_total on out_valid/out_ready.
// a two-word queue sits behind the input, so words are taken while the
// back end works or while an output word waits for the receiver.
// add and clear act in the back end as the word is taken, all lag cells at once.
// a bad-lag or empty query answers in the cycle after it is taken. a good
// query sums k history samples, runs the shared shift-add multiplier eight
// times with MBW = max(COUNT_BITS+2, 44) multiplier bits, then the restoring
// divider on NW = 2*COUNT_BITS + FRAC_BITS + 64 bit words, and saturates.
// nothing else is taken from the queue while a query runs.
// a stalled receiver holds the output word; further queries wait, adds go on.
// reset clears history, sums, count and the queue, and sets lags_in_use
// to 16; cfg_we writes lags_in_use at once.
// ----------------------------------------------------------------------------
module streaming_autocovariance
    import sacov_pkg::*;
#(
    parameter int MAX_LAG    = MAX_LAG_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [REQ_W-1:0]           req_type,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [LAG_W-1:0]           lag,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_wdata,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [ACOV_W-1:0]   autocov,
    output logic [STAT_W-1:0]          status,
    output logic [TOTAL_W-1:0]         sample_total
);

    localparam int HIW = $clog2(MAX_LAG+1);

    item_t                          item;
    logic                           item_valid, item_pop;
    logic                           q_start, q_busy, q_done;
    logic signed [ACOV_W-1:0]       q_result;
    logic [HIW-1:0]                 q_lag;
    logic signed [PROD_W-1:0]       q_prod;
    logic signed [EARLY_W-1:0]      q_early;
    logic signed [SUM_W-1:0]        q_sum;
    logic [COUNT_BITS-1:0]          q_count;
    logic [MAX_LAG:0][SAMPLE_W-1:0] hist;

    sacov_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .sample     (sample),
        .lag        (lag),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    sacov_query #(
        .MAX_LAG    (MAX_LAG),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_query (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (q_start),
        .lag_in   (q_lag),
        .prod_in  (q_prod),
        .early_in (q_early),
        .sum_in   (q_sum),
        .count_in (q_count),
        .hist     (hist),
        .busy     (q_busy),
        .done     (q_done),
        .result   (q_result)
    );

    sacov_back #(
        .MAX_LAG    (MAX_LAG),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .autocov      (autocov),
        .status       (status),
        .sample_total (sample_total),
        .q_start      (q_start),
        .q_busy       (q_busy),
        .q_done       (q_done),
        .q_result     (q_result),
        .q_lag        (q_lag),
        .q_prod       (q_prod),
        .q_early      (q_early),
        .q_sum        (q_sum),
        .q_count      (q_count),
        .hist         (hist)
    );

    // nothing leaves the queue while a query is in flight
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_busy |-> !item_pop)
        else $error("queue popped during query");

    // a finished estimate always finds the output register free
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_done |-> !out_valid)
        else $error("estimate done while output word pending");

    // a query start always comes from a popped word
    a_start_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_start |-> item_pop && item_valid && !q_busy)
        else $error("query started without a word");

endmodule
